### src/mhavg_pkg.sv
// ----------------------------------------------------------------------------
// mhavg_pkg
// shared types and constants of the magnetometer heading averager
// ----------------------------------------------------------------------------
package mhavg_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned VecW = 34;
  localparam int unsigned AngW = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_PREP,
    ST_CORDIC,
    ST_SCALE,
    ST_ACCUM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_CYX = 3'd0,
    REG_CYY = 3'd1,
    REG_CYZ = 3'd2,
    REG_CZX = 3'd3,
    REG_CZY = 3'd4,
    REG_CZZ = 3'd5,
    REG_OFY = 3'd6,
    REG_OFZ = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       load;
    logic       mac;
    logic [2:0] mac_idx;
    logic       prep;
    logic       cordic;
    logic [4:0] step;
    logic       scale;
    logic       accum;
    logic       div_start;
    logic       div_step;
  } cmd_t;

  typedef struct packed {
    logic batch_end;
  } sts_t;

  function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/mhavg_ctrl.sv
// ----------------------------------------------------------------------------
// mhavg_ctrl
// sequencer: matrix products, cordic steps, scaling, batch mean division
// ----------------------------------------------------------------------------
module mhavg_ctrl #(
  parameter int unsigned DivSteps = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mhavg_pkg::sts_t     sts,
  output mhavg_pkg::cmd_t     cmd
);

  mhavg_pkg::state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhavg_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      mhavg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mhavg_pkg::ST_MAC;
          cnt_nxt   = '0;
        end
      end
      mhavg_pkg::ST_MAC: begin
        if (cnt_r == 5'd5) begin
          state_nxt = mhavg_pkg::ST_PREP;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      mhavg_pkg::ST_PREP: begin
        state_nxt = mhavg_pkg::ST_CORDIC;
        cnt_nxt   = '0;
      end
      mhavg_pkg::ST_CORDIC: begin
        if (cnt_r == 5'(mhavg_pkg::CordicSteps - 1)) begin
          state_nxt = mhavg_pkg::ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      mhavg_pkg::ST_SCALE: state_nxt = mhavg_pkg::ST_ACCUM;
      mhavg_pkg::ST_ACCUM: begin
        cnt_nxt = '0;
        if (sts.batch_end) state_nxt = mhavg_pkg::ST_DIV;
        else state_nxt = mhavg_pkg::ST_IDLE;
      end
      mhavg_pkg::ST_DIV: begin
        if (cnt_r == 5'(DivSteps - 1)) state_nxt = mhavg_pkg::ST_OUT;
        else cnt_nxt = cnt_r + 5'd1;
      end
      mhavg_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = mhavg_pkg::ST_IDLE;
      end
      default: state_nxt = mhavg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.step    = cnt_r;
    cmd.mac_idx = cnt_r[2:0];
    case (state_r)
      mhavg_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid;
      end
      mhavg_pkg::ST_MAC:    cmd.mac = 1'b1;
      mhavg_pkg::ST_PREP:   cmd.prep = 1'b1;
      mhavg_pkg::ST_CORDIC: cmd.cordic = 1'b1;
      mhavg_pkg::ST_SCALE:  cmd.scale = 1'b1;
      mhavg_pkg::ST_ACCUM: begin
        cmd.accum     = 1'b1;
        cmd.div_start = sts.batch_end;
      end
      mhavg_pkg::ST_DIV:    cmd.div_step = 1'b1;
      mhavg_pkg::ST_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == mhavg_pkg::ST_IDLE) else $error("stall low outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("input taken while result pending");
`endif

endmodule

### src/mhavg_dp.sv
// ----------------------------------------------------------------------------
// mhavg_dp
// datapath: shared multiplier, iterative cordic, sum and reciprocal mean
// ----------------------------------------------------------------------------
module mhavg_dp #(
  parameter int unsigned Samples = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mhavg_pkg::cmd_t     cmd,
  output mhavg_pkg::sts_t     sts,
  input  logic signed [12:0]  raw_x,
  input  logic signed [12:0]  raw_y,
  input  logic signed [12:0]  raw_z,
  input  logic signed [15:0]  coef [6],
  input  logic signed [23:0]  ofs_y,
  input  logic signed [23:0]  ofs_z,
  output logic [15:0]         heading
);

  localparam int unsigned VW = mhavg_pkg::VecW;
  localparam int unsigned AW = mhavg_pkg::AngW;
  localparam logic [4:0] SamplesC = 5'(Samples);
  localparam int unsigned DivShift = 20 + $clog2(Samples);
  localparam longint unsigned DivMulL =
    ((64'd1 << DivShift) + 64'(Samples) - 64'd1) / 64'(Samples);
  localparam logic [21:0] DivMul = 22'(DivMulL);

  logic signed [12:0] x_r, y_in_r, z_in_r;
  logic signed [VW-1:0] vy_r, vz_r, vy_nxt, vz_nxt;
  logic [AW-1:0] ang_r;
  logic zero_r;
  logic [15:0] h_r;
  logic [3:0] count_r;
  logic [19:0] sum_r;
  logic [19:0] div_r, quo_r;
  logic signed [12:0] mop;
  logic signed [28:0] prod;
  logic [AW+15:0] sprod;
  logic [43:0] dprod;
  logic [4:0] cnt_plus;
  logic [19:0] sum_plus;

  always_comb begin
    case (cmd.mac_idx)
      3'd0, 3'd3: mop = x_r;
      3'd1, 3'd4: mop = y_in_r;
      default:    mop = z_in_r;
    endcase
    prod = coef[cmd.mac_idx < 3'd6 ? cmd.mac_idx : 3'd0] * mop;
  end

  always_comb begin
    if (!vz_r[VW-1]) begin
      vy_nxt = vy_r + (vz_r >>> cmd.step);
      vz_nxt = vz_r - (vy_r >>> cmd.step);
    end else begin
      vy_nxt = vy_r - (vz_r >>> cmd.step);
      vz_nxt = vz_r + (vy_r >>> cmd.step);
    end
  end

  assign sprod    = {16'd0, ang_r} * 48'd36000;
  assign cnt_plus = {1'b0, count_r} + 5'd1;
  assign sum_plus = sum_r + 20'(h_r);
  assign sts.batch_end = cnt_plus >= SamplesC;
  assign dprod    = 44'(div_r) * 44'(DivMul);
  assign heading  = quo_r[15:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= raw_x;
      y_in_r <= raw_y;
      z_in_r <= raw_z;
      vy_r   <= -VW'(ofs_y);
      vz_r   <= -VW'(ofs_z);
    end
    if (cmd.mac) begin
      if (cmd.mac_idx < 3'd3) vy_r <= vy_r + VW'(prod);
      else vz_r <= vz_r + VW'(prod);
    end
    if (cmd.prep) begin
      zero_r <= (vy_r == '0) && (vz_r == '0);
      if (vy_r[VW-1]) begin
        vy_r  <= -vy_r;
        vz_r  <= -vz_r;
        ang_r <= {1'b1, {(AW-1){1'b0}}};
      end else begin
        ang_r <= '0;
      end
    end
    if (cmd.cordic) begin
      vy_r <= vy_nxt;
      vz_r <= vz_nxt;
      if (!vz_r[VW-1]) ang_r <= ang_r + mhavg_pkg::atan_entry(cmd.step);
      else ang_r <= ang_r - mhavg_pkg::atan_entry(cmd.step);
    end
    if (cmd.scale) h_r <= zero_r ? 16'd0 : sprod[AW+15:AW];
    if (cmd.div_start) div_r <= sum_plus;
    if (cmd.div_step) quo_r <= dprod[DivShift +: 20];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.accum) begin
      if (sts.batch_end) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        count_r <= cnt_plus[3:0];
        sum_r   <= sum_plus;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} < SamplesC) else $error("sample count beyond batch");
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum |-> h_r < 16'd36000) else $error("heading out of range");
  a_clear_batch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum && sts.batch_end |=> count_r == '0 && sum_r == '0)
    else $error("batch not cleared");
`endif

endmodule

### src/magnetometer_heading_averager_unit.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_averager_unit
// soft-iron calibrated atan2 heading, averaged over a batch of samples
// ----------------------------------------------------------------------------
// Each item is accepted in idle, then takes the matrix products on one shared
// 16x13 multiplier, quadrant folding, the iterative cordic, the degree
// scaling and the accumulation; no new item is accepted before it is done.
// The last item of a batch then takes the mean, a reciprocal multiplication,
// and holds its result until it is taken; no item is accepted meanwhile.
module magnetometer_heading_averager_unit #(
  parameter int unsigned SAMPLES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [12:0] in_raw_x,
  input  logic signed [12:0] in_raw_y,
  input  logic signed [12:0] in_raw_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_heading_centidegrees,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned DivSteps = 1;

  logic signed [15:0] coef_r [6];
  logic signed [23:0] ofs_y_r, ofs_z_r;
  mhavg_pkg::cmd_t cmd;
  mhavg_pkg::sts_t sts;
  mhavg_pkg::reg_idx_t ridx;
  logic wr;

  assign cfg_pready = 1'b1;
  assign ridx = mhavg_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= -16'sd143;
      coef_r[1] <= 16'sd5956;
      coef_r[2] <= -16'sd393;
      coef_r[3] <= 16'sd332;
      coef_r[4] <= 16'sd16;
      coef_r[5] <= 16'sd6689;
      ofs_y_r   <= 24'sd1329906;
      ofs_z_r   <= 24'sd1436148;
    end else if (wr) begin
      case (ridx)
        mhavg_pkg::REG_OFY: ofs_y_r <= cfg_pwdata[23:0];
        mhavg_pkg::REG_OFZ: ofs_z_r <= cfg_pwdata[23:0];
        default: coef_r[ridx] <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mhavg_pkg::REG_OFY: cfg_prdata = {8'd0, ofs_y_r};
      mhavg_pkg::REG_OFZ: cfg_prdata = {8'd0, ofs_z_r};
      default: cfg_prdata = {16'd0, coef_r[ridx]};
    endcase
  end

  mhavg_ctrl #(.DivSteps(DivSteps)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  mhavg_dp #(.Samples(SAMPLES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .raw_x(in_raw_x), .raw_y(in_raw_y), .raw_z(in_raw_z),
    .coef(coef_r), .ofs_y(ofs_y_r), .ofs_z(ofs_z_r),
    .heading(out_heading_centidegrees)
  );

endmodule

### dv/tb_magnetometer_heading_averager_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magnetometer_heading_averager_unit
// checks the batch-mean heading against an in-bench predictor of the
// calibration, cordic atan2 and averaging, over several register settings
// and idle and stall patterns, with one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_magnetometer_heading_averager_unit;

  localparam int unsigned BatchLen = 5;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [12:0] z;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [12:0] in_raw_x = '0;
  logic signed [12:0] in_raw_y = '0;
  logic signed [12:0] in_raw_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_heading_centidegrees;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sample_t pending_samples[$];
  logic [15:0] expected_means[$];
  longint calib[8];
  int unsigned batch_count;
  logic [19:0] batch_sum;
  bit in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  magnetometer_heading_averager_unit #(.SAMPLES(BatchLen)) uut (.*);

  always #10 clk = ~clk;

  function automatic logic [15:0] heading_of_vector(longint y, longint z);
    logic [31:0] atan_steps[20] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304};
    logic [31:0] ang;
    longint ny;
    longint nz;
    logic [63:0] scaled;
    ang = '0;
    if (y == 0 && z == 0) return '0;
    if (y < 0) begin
      y = -y;
      z = -z;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        ny = y + (z >>> i);
        nz = z - (y >>> i);
        ang += atan_steps[i];
      end else begin
        ny = y - (z >>> i);
        nz = z + (y >>> i);
        ang -= atan_steps[i];
      end
      y = ny;
      z = nz;
    end
    scaled = 64'(ang) * 64'd36000;
    return 16'(scaled >> 32);
  endfunction

  task automatic absorb_sample(input sample_t s);
    longint cy;
    longint cz;
    cy = calib[mhavg_pkg::REG_CYX] * s.x + calib[mhavg_pkg::REG_CYY] * s.y
       + calib[mhavg_pkg::REG_CYZ] * s.z - calib[mhavg_pkg::REG_OFY];
    cz = calib[mhavg_pkg::REG_CZX] * s.x + calib[mhavg_pkg::REG_CZY] * s.y
       + calib[mhavg_pkg::REG_CZZ] * s.z - calib[mhavg_pkg::REG_OFZ];
    batch_sum = batch_sum + 20'(heading_of_vector(cy, cz));
    batch_count++;
    if (batch_count >= BatchLen) begin
      expected_means.push_back(16'(batch_sum / BatchLen));
      batch_count = 0;
      batch_sum = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic write_reg(input mhavg_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= value;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx <= mhavg_pkg::REG_CZZ) calib[idx] = longint'($signed(value[15:0]));
    else calib[idx] = longint'($signed(value[23:0]));
  endtask

  task automatic write_all(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(mhavg_pkg::reg_idx_t'(i), v[i]);
  endtask

  task automatic push_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = 13'(x);
    s.y = 13'(y);
    s.z = 13'(z);
    pending_samples.push_back(s);
  endtask

  task automatic push_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_sample($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
                    $urandom_range(0, 255) - 128);
      else
        push_sample($urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain;
    wait (pending_samples.size() == 0 && !in_valid && expected_means.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 55; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 55; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_samples.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        in_raw_x <= pending_samples[0].x;
        in_raw_y <= pending_samples[0].y;
        in_raw_z <= pending_samples[0].z;
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(1, 100) <= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    sample_t s;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("magnetometer_heading_averager_unit verification failed");
      $finish;
    end
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      s.x = in_raw_x;
      s.y = in_raw_y;
      s.z = in_raw_z;
      absorb_sample(s);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("unexpected item %0d", out_heading_centidegrees));
      end else begin
        if (out_heading_centidegrees !== expected_means[0])
          report_mismatch($sformatf("heading %0d, expected %0d",
                                    out_heading_centidegrees, expected_means[0]));
        void'(expected_means.pop_front());
      end
    end
  end

  initial begin
    logic [31:0] v[8];
    calib = '{-143, 5956, -393, 332, 16, 6689, 1329906, 1436148};
    batch_count = 0;
    batch_sum = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes with reset calibration
    push_sample(-4096, -4096, -4096);
    push_sample(4095, 4095, 4095);
    push_sample(0, 0, 0);
    push_sample(-4096, 4095, 0);
    push_sample(4095, -4096, 0);
    push_sample(0, 4095, -4096);
    push_sample(0, -4096, 4095);
    push_sample(4095, 0, 4095);
    push_sample(-4096, 0, -4096);
    push_sample(1, -1, 1);
    drain();

    // zero vector
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    write_all(v);
    push_sample(4095, -4096, 123);
    push_sample(0, 0, 0);
    push_sample(-4096, 4095, -4096);
    push_sample(77, 88, 99);
    push_sample(-1, -1, -1);
    // identity-like rows, negative y axis and angle near zero
    drain();
    v = '{0, 4096, 0, 0, 0, 4096, 0, 0};
    write_all(v);
    push_sample(0, 100, 0);
    push_sample(0, -100, 0);
    push_sample(0, 0, 100);
    push_sample(0, 0, -100);
    push_sample(0, 100, -1);
    push_sample(0, -4096, 1);
    push_sample(0, -4096, -1);
    push_sample(0, 4095, 4095);
    push_sample(0, -4096, -4096);
    push_sample(0, 1, 0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase % 4);
      case (phase)
        0: v = '{32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff,
                 32'h7fffff, 32'h7fffff};
        1: v = '{32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000,
                 32'h800000, 32'h800000};
        2: v = '{-143, 5956, -393, 332, 16, 6689, 1329906, 1436148};
        default: begin
          for (int i = 0; i < 8; i++) v[i] = $urandom;
          if (phase == 4) begin
            v[mhavg_pkg::REG_OFY] = $urandom_range(0, 4095);
            v[mhavg_pkg::REG_OFZ] = $urandom_range(0, 4095);
          end
        end
      endcase
      write_all(v);
      if (phase == 5) begin
        push_random(240);
        fork
          begin
            repeat (20) @(posedge clk);
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end else begin
        push_random(235);
      end
      drain();
    end

    if (errors == 0) begin
      $display("magnetometer_heading_averager_unit verification clean");
    end else begin
      $display("magnetometer_heading_averager_unit verification failed");
    end
    $finish;
  end

endmodule
